FILE: rtl/mep_pkg.sv
// shared constants, types and helper functions for the mandelbrot escape-time pixel block
// used by the interfaces, the iteration core and the top level; no dependencies
`default_nettype none

package mep_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 10;
    localparam int ITER_W  = 12;
    localparam int COLOR_W = 8;
    localparam int Z_W     = 32;
    localparam int STEP_W  = 31;
    localparam int PROD_W  = 2 * Z_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_STEP   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_ORIGIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [Z_W-1:0] X_ORIGIN_RST = -32'sd536870912;
    localparam logic [STEP_W-1:0]     X_STEP_RST   = 31'd786432;
    localparam logic signed [Z_W-1:0] Y_ORIGIN_RST = -32'sd402653184;
    localparam logic [STEP_W-1:0]     Y_STEP_RST   = 31'd786432;
    localparam logic [ITER_W-1:0]     MAX_ITER_RST = 12'd256;

    // escape when |z|^2 > 4 in the squared scale
    localparam bit CAN_ESCAPE = (2 * FRAC_BITS + 2) < PROD_W;
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << ((2 * FRAC_BITS) % PROD_W);

    localparam logic signed [SUM_W-1:0] Z_MAX_EXT =
        {{(SUM_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] Z_MIN_EXT =
        {{(SUM_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};

    typedef struct packed {
        logic [Z_W-1:0]    x_origin;
        logic [STEP_W-1:0] x_step;
        logic [Z_W-1:0]    y_origin;
        logic [STEP_W-1:0] y_step;
        logic [ITER_W-1:0] max_iterations;
    } mep_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   out_x;
        logic [PIX_W-1:0]   out_y;
        logic [ITER_W-1:0]  iterations;
        logic               inside_res;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } mep_result_t;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > Z_MAX_EXT)
            r = Z_MAX_EXT[Z_W-1:0];
        else if (v < Z_MIN_EXT)
            r = Z_MIN_EXT[Z_W-1:0];
        else
            r = v[Z_W-1:0];
        return r;
    endfunction

    // palette entry as {red, green, blue}
    function automatic logic [3*COLOR_W-1:0] palette(input logic [3:0] idx);
        logic [3*COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = {8'd66,  8'd30,  8'd15};
            4'd1:    c = {8'd25,  8'd7,   8'd26};
            4'd2:    c = {8'd9,   8'd1,   8'd47};
            4'd3:    c = {8'd4,   8'd4,   8'd73};
            4'd4:    c = {8'd0,   8'd7,   8'd100};
            4'd5:    c = {8'd134, 8'd181, 8'd229};
            4'd6:    c = {8'd211, 8'd236, 8'd248};
            4'd7:    c = {8'd248, 8'd201, 8'd95};
            4'd8:    c = {8'd255, 8'd170, 8'd0};
            4'd9:    c = {8'd204, 8'd128, 8'd0};
            4'd10:   c = {8'd153, 8'd87,  8'd0};
            4'd11:   c = {8'd153, 8'd87,  8'd0};
            4'd12:   c = {8'd106, 8'd52,  8'd4};
            4'd13:   c = {8'd205, 8'd133, 8'd0};
            4'd14:   c = {8'd129, 8'd90,  8'd0};
            default: c = {8'd255, 8'd250, 8'd240};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mep_pixel_if.sv
// valid/ready channel carrying one pixel coordinate
// depends on mep_pkg
`default_nettype none

interface mep_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [mep_pkg::PIX_W-1:0] pixel_x;
    logic [mep_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/mep_result_if.sv
// valid/ready channel carrying one escape-time result with its color
// depends on mep_pkg
`default_nettype none

interface mep_result_if;
    logic                        valid;
    logic                        ready;
    logic [mep_pkg::PIX_W-1:0]   out_x;
    logic [mep_pkg::PIX_W-1:0]   out_y;
    logic [mep_pkg::ITER_W-1:0]  iterations;
    logic                        inside_res;
    logic [mep_pkg::COLOR_W-1:0] red;
    logic [mep_pkg::COLOR_W-1:0] green;
    logic [mep_pkg::COLOR_W-1:0] blue;

    modport source (output valid, output out_x, output out_y, output iterations,
                    output inside_res, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input iterations,
                    input inside_res, input red, input green, input blue,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/mandelbrot_escape_pixel.sv
// top level of the mandelbrot escape-time pixel block: config registers and result register
// depends on mep_pkg, mep_pixel_if, mep_result_if and mep_core
//
//   channel   direction  payload                                        transfer when
//   pixel     in         pixel_x, pixel_y                               valid & ready
//   result    out        out_x, out_y, iterations, inside_res, r, g, b  valid & ready
//   cfg       in         cfg_addr, cfg_wdata                            cfg_wr_en
//
// after the pixel transfer the core steps through CR, CI and START, then runs n iterations, n the
// iteration count (1..max_iterations, 1 when the limit is 0), each through UPD, RR, II and CHK
// around the shared 32x32 multiplier; the next pixel can be taken in the cycle after the core
// result moves to the result register; one result may wait there while the core works
// reset (rst_n, async low) loads the default view and a limit of 256
`default_nettype none

module mandelbrot_escape_pixel (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mep_pixel_if.sink                              pixel,
    mep_result_if.source                           result,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mep_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [mep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    mep_pkg::mep_cfg_t    cfg_reg;
    mep_pkg::mep_result_t core_res, out_reg;
    logic                 core_idle, core_valid, core_take;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin       <= mep_pkg::X_ORIGIN_RST;
            cfg_reg.x_step         <= mep_pkg::X_STEP_RST;
            cfg_reg.y_origin       <= mep_pkg::Y_ORIGIN_RST;
            cfg_reg.y_step         <= mep_pkg::Y_STEP_RST;
            cfg_reg.max_iterations <= mep_pkg::MAX_ITER_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                mep_pkg::REG_X_ORIGIN: cfg_reg.x_origin <= cfg_wdata;
                mep_pkg::REG_X_STEP:   cfg_reg.x_step   <= cfg_wdata[mep_pkg::STEP_W-1:0];
                mep_pkg::REG_Y_ORIGIN: cfg_reg.y_origin <= cfg_wdata;
                mep_pkg::REG_Y_STEP:   cfg_reg.y_step   <= cfg_wdata[mep_pkg::STEP_W-1:0];
                mep_pkg::REG_MAX_ITER:
                    cfg_reg.max_iterations <= cfg_wdata[mep_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    mep_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pixel.valid),
        .px        (pixel.pixel_x),
        .py        (pixel.pixel_y),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_take  (core_take),
        .res       (core_res)
    );

    assign pixel.ready = core_idle;

    // move the core result into the output register once it is free
    assign core_take = core_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (core_take)
            out_reg <= core_res;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_x      = out_reg.out_x;
    assign result.out_y      = out_reg.out_y;
    assign result.iterations = out_reg.iterations;
    assign result.inside_res = out_reg.inside_res;
    assign result.red        = out_reg.red;
    assign result.green      = out_reg.green;
    assign result.blue       = out_reg.blue;

endmodule

`default_nettype wire

FILE: rtl/mep_core.sv
// iteration core: one shared 32x32 signed multiplier under a small sequencer
// forms c, iterates z = z*z + c with saturation and the escape test; depends on mep_pkg
`default_nettype none

module mep_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mep_pkg::PIX_W-1:0]     px,
    input  wire logic [mep_pkg::PIX_W-1:0]     py,
    input  wire mep_pkg::mep_cfg_t             cfg,
    output logic                               idle,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output mep_pkg::mep_result_t               res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CR    = 3'd1;
    localparam logic [2:0] S_CI    = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_RR    = 3'd5;
    localparam logic [2:0] S_II    = 3'd6;
    localparam logic [2:0] S_CHK   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       done_reg;

    logic [mep_pkg::PIX_W-1:0]         px_reg, py_reg;
    logic [mep_pkg::PIX_W-1:0]         cx, cy;
    logic signed [mep_pkg::Z_W-1:0]    zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [mep_pkg::PROD_W-1:0] prod_reg, rr_reg;
    logic signed [mep_pkg::DIFF_W-1:0] d_reg;
    logic [mep_pkg::ITER_W-1:0]        iter_reg, lim;

    logic signed [mep_pkg::Z_W-1:0]    mul_a, mul_b;
    logic signed [mep_pkg::PROD_W-1:0] mul_p;
    logic signed [mep_pkg::Z_W-1:0]    nr, ni, cr_new, ci_new;
    logic [mep_pkg::PROD_W-1:0]        mag;
    logic                              finish;
    logic [3*mep_pkg::COLOR_W-1:0]     color;

    assign cx = (px_reg > mep_pkg::PIX_W'(mep_pkg::MAX_WIDTH - 1))
              ? mep_pkg::PIX_W'(mep_pkg::MAX_WIDTH - 1) : px_reg;
    assign cy = (py_reg > mep_pkg::PIX_W'(mep_pkg::MAX_HEIGHT - 1))
              ? mep_pkg::PIX_W'(mep_pkg::MAX_HEIGHT - 1) : py_reg;

    assign lim = (cfg.max_iterations == '0) ? mep_pkg::ITER_W'(1) : cfg.max_iterations;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = zr_reg;
        mul_b = zi_reg;
        unique case (state_reg)
            S_CR:
            begin
                mul_a = mep_pkg::Z_W'(cx);
                mul_b = {1'b0, cfg.x_step};
            end
            S_CI:
            begin
                mul_a = mep_pkg::Z_W'(cy);
                mul_b = {1'b0, cfg.y_step};
            end
            S_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p = mep_pkg::PROD_W'(mul_a) * mep_pkg::PROD_W'(mul_b);

    assign cr_new = mep_pkg::sat_z(mep_pkg::SUM_W'($signed(cfg.x_origin))
                                   + mep_pkg::SUM_W'(prod_reg));
    assign ci_new = mep_pkg::sat_z(mep_pkg::SUM_W'($signed(cfg.y_origin))
                                   + mep_pkg::SUM_W'(prod_reg));

    // floor scaling by arithmetic shift, then add c and saturate
    assign nr = mep_pkg::sat_z(mep_pkg::SUM_W'(d_reg >>> mep_pkg::FRAC_BITS)
                               + mep_pkg::SUM_W'(cr_reg));
    assign ni = mep_pkg::sat_z(mep_pkg::SUM_W'(prod_reg >>> (mep_pkg::FRAC_BITS - 1))
                               + mep_pkg::SUM_W'(ci_reg));

    // both terms are squares, so the unsigned sum cannot wrap
    assign mag    = $unsigned(rr_reg) + $unsigned(prod_reg);
    assign finish = (mep_pkg::CAN_ESCAPE && (mag > mep_pkg::ESC_LIMIT)) || (iter_reg >= lim);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start && !done_reg) state_next = S_CR;
            S_CR:    state_next = S_CI;
            S_CI:    state_next = S_START;
            S_START: state_next = S_UPD;
            S_UPD:   state_next = S_RR;
            S_RR:    state_next = S_II;
            S_II:    state_next = S_CHK;
            S_CHK:   state_next = finish ? S_IDLE : S_UPD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CHK && finish)
                done_reg <= 1'b1;
            else if (res_take)
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    px_reg   <= px;
                    py_reg   <= py;
                    zr_reg   <= '0;
                    zi_reg   <= '0;
                    rr_reg   <= '0;
                    d_reg    <= '0;
                    iter_reg <= '0;
                end
            end
            S_CI:    cr_reg <= cr_new;
            S_START: ci_reg <= ci_new;
            S_UPD:
            begin
                zr_reg   <= nr;
                zi_reg   <= ni;
                iter_reg <= iter_reg + mep_pkg::ITER_W'(1);
            end
            S_II:    rr_reg <= prod_reg;
            S_CHK:   d_reg <= mep_pkg::DIFF_W'(rr_reg) - mep_pkg::DIFF_W'(prod_reg);
            default: ;
        endcase
    end

    assign idle      = (state_reg == S_IDLE) && !done_reg;
    assign res_valid = done_reg;

    assign color = mep_pkg::palette(iter_reg[3:0]);

    always_comb
    begin
        res.out_x      = px_reg;
        res.out_y      = py_reg;
        res.iterations = iter_reg;
        res.inside_res = (iter_reg == lim);
        res.red        = res.inside_res ? '0 : color[3*mep_pkg::COLOR_W-1:2*mep_pkg::COLOR_W];
        res.green      = res.inside_res ? '0 : color[2*mep_pkg::COLOR_W-1:mep_pkg::COLOR_W];
        res.blue       = res.inside_res ? '0 : color[mep_pkg::COLOR_W-1:0];
    end

endmodule

`default_nettype wire
